// ----- src/pga_pkg.sv -----
`timescale 1ns / 1ps

package pga_pkg;

    localparam logic [31:0] Q30_ONE     = 32'd1073741824;
    localparam logic [33:0] PI_Q30      = 34'd3373259426;
    localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
    localparam logic [29:0] NORM_LOW    = 30'h2000_0000;
    localparam logic [2:0]  COS_LAST    = 3'd7;
    localparam logic [2:0]  SIN_LAST    = 3'd6;

    localparam logic [1:0] REQ_SAMPLE    = 2'd0;
    localparam logic [1:0] REQ_ABS_AXANG = 2'd1;
    localparam logic [1:0] REQ_ABS_QUAT  = 2'd2;
    localparam logic [1:0] REQ_DELTA     = 2'd3;

    localparam logic GOAL_POSE  = 1'b0;
    localparam logic GOAL_TWIST = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rot_ax;
        logic signed [31:0] rot_ay;
        logic signed [31:0] rot_az;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
    } t_in;

    typedef struct packed {
        logic               goal_kind;
        logic signed [31:0] lin_x;
        logic signed [31:0] lin_y;
        logic signed [31:0] lin_z;
        logic signed [31:0] ang_x;
        logic signed [31:0] ang_y;
        logic signed [31:0] ang_z;
        logic signed [31:0] ang_w;
    } t_out;

    function automatic logic [7:0] cos_den(input logic [2:0] i);
        logic [7:0] d;
        unique case (i)
            3'd0: d = 8'd2;
            3'd1: d = 8'd12;
            3'd2: d = 8'd30;
            3'd3: d = 8'd56;
            3'd4: d = 8'd90;
            3'd5: d = 8'd132;
            3'd6: d = 8'd182;
            3'd7: d = 8'd240;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] sin_den(input logic [2:0] i);
        logic [7:0] d;
        unique case (i)
            3'd0: d = 8'd6;
            3'd1: d = 8'd20;
            3'd2: d = 8'd42;
            3'd3: d = 8'd72;
            3'd4: d = 8'd110;
            3'd5: d = 8'd156;
            3'd6: d = 8'd210;
            default: d = 8'd210;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = sx33(a) + sx33(b);
        if (s[32] != s[31]) begin
            r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    // Terms of the Hamilton product that enter with a minus sign.
    function automatic logic ham_neg(input logic [1:0] k, input logic [1:0] j);
        return (k == 2'd0 && j != 2'd0) || (k == 2'd1 && j == 2'd3) ||
               (k == 2'd2 && j == 2'd1) || (k == 2'd3 && j == 2'd2);
    endfunction

endpackage

// ----- src/pga_div.sv -----
`timescale 1ns / 1ps

module pga_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_dvs;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_nx;

    assign rem_sh = {r_rem[31:0], r_q[63]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign rem_nx = ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[62:0], ge};
                r_rem <= rem_nx;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- src/pga_isqrt.sv -----
`timescale 1ns / 1ps

module pga_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [32:0] r_rem;
    logic [31:0] r_root;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic [34:0] rem_df;
    logic        ge;

    assign rem_sh = {r_rem, r_rad[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem_sh >= trial;
    assign rem_df = rem_sh - trial;
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= {r_rad[61:0], 2'b00};
                r_rem  <= ge ? rem_df[32:0] : rem_sh[32:0];
                r_root <= {r_root[30:0], ge};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ----- src/pga_core.sv -----
`timescale 1ns / 1ps

module pga_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pga_pkg::t_in  i_item,
    input  logic          i_mode,
    input  logic          i_out_free,
    output logic          o_busy,
    output logic          o_res_valid,
    output pga_pkg::t_out o_res
);
    import pga_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE, S_AA_SQ_MUL, S_AA_SQ_ACC, S_AA_SQRT_GO, S_AA_SQRT_WAIT, S_AA_RED,
        S_AA_FOLD, S_AA_X2_MUL, S_AA_X2_ACC, S_SER_MUL, S_SER_DIV_GO, S_SER_DIV_WAIT,
        S_AA_S_MUL, S_AA_S_ACC, S_VEC_MUL, S_VEC_DIV_GO, S_VEC_DIV_WAIT, S_AA_RAW,
        S_C_INIT, S_C_SHIFT, S_C_SQ_MUL, S_C_SQ_ACC, S_C_SQRT_GO, S_C_SQRT_WAIT,
        S_C_DIV_GO, S_C_DIV_WAIT, S_C_DOT_MUL, S_C_DOT_ACC, S_C_FLIP, S_RET,
        S_DELTA, S_HAM_MUL, S_HAM_ACC, S_OUT
    } t_state;

    typedef enum logic [1:0] {PH_AA, PH_SEED, PH_Q1, PH_FINAL} t_phase;

    t_state             r_state;
    t_phase             r_phase;
    t_in                r_item;
    logic               r_twist;
    logic               r_use_ref;
    logic               r_has_ref;
    logic signed [31:0] r_refpos [3];
    logic signed [31:0] r_refq   [4];
    logic signed [31:0] r_spos   [3];
    logic signed [31:0] r_sq     [4];
    logic signed [31:0] r_dq     [4];
    logic signed [31:0] r_o      [4];
    logic signed [63:0] r_v      [4];
    logic [63:0]        r_u      [4];
    logic [63:0]        r_acc;
    logic [63:0]        r_prod;
    logic [3:0]         r_idx;
    logic [31:0]        r_ang;
    logic [33:0]        r_h;
    logic               r_neg;
    logic               r_cneg;
    logic [31:0]        r_x;
    logic [31:0]        r_x2;
    logic [30:0]        r_t;
    logic [30:0]        r_c;
    logic [30:0]        r_s;
    logic               r_ser_sin;
    logic [31:0]        r_n;

    logic signed [31:0] rot_a [3];
    logic signed [31:0] pos_a [3];
    logic signed [31:0] qin_a [4];
    logic [31:0]        mg;
    logic [63:0]        m01;
    logic [63:0]        m23;
    logic [63:0]        m;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic               div_start;
    logic [63:0]        div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic [63:0]        div_quot;
    logic               sq_start;
    logic               sq_done;
    logic [31:0]        sq_root;
    logic [30:0]        ser_t;
    logic [1:0]         ham_k;
    logic [1:0]         ham_j;
    logic [63:0]        acc_sum;
    logic [31:0]        qlo;
    logic               flip;

    assign rot_a = '{r_item.rot_ax, r_item.rot_ay, r_item.rot_az};
    assign pos_a = '{r_item.pos_x, r_item.pos_y, r_item.pos_z};
    assign qin_a = '{r_item.quat_w, r_item.quat_x, r_item.quat_y, r_item.quat_z};
    assign mg    = mag32(rot_a[r_idx[1:0]]);
    assign m01   = (r_u[0] > r_u[1]) ? r_u[0] : r_u[1];
    assign m23   = (r_u[2] > r_u[3]) ? r_u[2] : r_u[3];
    assign m     = (m01 > m23) ? m01 : m23;
    assign ham_k = r_idx[3:2];
    assign ham_j = r_idx[1:0];
    assign acc_sum = r_acc + r_prod;
    assign qlo   = div_quot[31:0];
    assign ser_t = (div_quot >= {32'd0, Q30_ONE}) ? 31'd0 : 31'({32'd0, Q30_ONE} - div_quot);
    assign flip  = r_use_ref ? r_acc[63] : r_o[0][31];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_AA_SQ_MUL: begin
                mul_a = {1'b0, mg};
                mul_b = {1'b0, mg};
            end
            S_AA_X2_MUL: begin
                mul_a = {1'b0, r_x};
                mul_b = {1'b0, r_x};
            end
            S_SER_MUL: begin
                mul_a = {1'b0, r_x2};
                mul_b = {2'b00, r_t};
            end
            S_AA_S_MUL: begin
                mul_a = {1'b0, r_x};
                mul_b = {2'b00, r_t};
            end
            S_VEC_MUL: begin
                mul_a = {2'b00, r_s};
                mul_b = {1'b0, mg};
            end
            S_C_SQ_MUL: begin
                mul_a = {3'b000, r_u[r_idx[1:0]][29:0]};
                mul_b = {3'b000, r_u[r_idx[1:0]][29:0]};
            end
            S_C_DOT_MUL: begin
                mul_a = sx33(r_o[r_idx[1:0]]);
                mul_b = sx33(r_refq[r_idx[1:0]]);
            end
            S_HAM_MUL: begin
                mul_a = sx33(r_dq[ham_j]);
                mul_b = sx33(r_refq[ham_k ^ ham_j]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sq_start     = 1'b0;
        unique case (r_state)
            S_SER_DIV_GO: begin
                div_start    = 1'b1;
                div_dividend = {30'd0, r_prod[63:30]};
                div_divisor  = {24'd0, r_ser_sin ? sin_den(r_idx[2:0]) : cos_den(r_idx[2:0])};
            end
            S_VEC_DIV_GO: begin
                div_start    = 1'b1;
                div_dividend = r_prod;
                div_divisor  = r_ang;
            end
            S_C_DIV_GO: begin
                div_start    = 1'b1;
                div_dividend = {4'd0, r_u[r_idx[1:0]][29:0], 30'd0};
                div_divisor  = r_n;
            end
            S_AA_SQRT_GO, S_C_SQRT_GO: begin
                sq_start = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    pga_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    pga_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_acc),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_AA;
            r_twist   <= 1'b0;
            r_use_ref <= 1'b0;
            r_has_ref <= 1'b0;
            r_idx     <= '0;
            for (int i = 0; i < 3; i++) begin
                r_refpos[i] <= '0;
                r_spos[i]   <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_refq[i] <= '0;
                r_sq[i]   <= '0;
            end
            r_refq[0] <= Q30_ONE;
            r_sq[0]   <= Q30_ONE;
        end else begin
            r_prod <= mul_p[63:0];
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_item  <= i_item;
                        r_twist <= 1'b0;
                        r_idx   <= '0;
                        r_acc   <= '0;
                        if (i_item.req_type == REQ_SAMPLE) begin
                            r_spos <= '{i_item.pos_x, i_item.pos_y, i_item.pos_z};
                            r_sq   <= '{i_item.quat_w, i_item.quat_x,
                                        i_item.quat_y, i_item.quat_z};
                        end else if (!i_mode) begin
                            r_twist <= 1'b1;
                            r_state <= S_OUT;
                        end else if (i_item.req_type == REQ_ABS_QUAT) begin
                            r_v       <= '{sx64(i_item.quat_w), sx64(i_item.quat_x),
                                           sx64(i_item.quat_y), sx64(i_item.quat_z)};
                            r_phase   <= PH_Q1;
                            r_use_ref <= 1'b0;
                            r_state   <= S_C_INIT;
                        end else begin
                            r_phase <= PH_AA;
                            r_state <= S_AA_SQ_MUL;
                        end
                    end
                end
                S_AA_SQ_MUL: r_state <= S_AA_SQ_ACC;
                S_AA_SQ_ACC: begin
                    r_acc <= acc_sum;
                    if (r_idx == 4'd2) begin
                        if (acc_sum == 64'd0) begin
                            r_o     <= '{Q30_ONE, 32'sd0, 32'sd0, 32'sd0};
                            r_state <= S_RET;
                        end else begin
                            r_state <= S_AA_SQRT_GO;
                        end
                    end else begin
                        r_idx   <= r_idx + 4'd1;
                        r_state <= S_AA_SQ_MUL;
                    end
                end
                S_AA_SQRT_GO: r_state <= S_AA_SQRT_WAIT;
                S_AA_SQRT_WAIT: begin
                    if (sq_done) begin
                        r_ang   <= sq_root;
                        r_h     <= {1'b0, sq_root, 1'b0};
                        r_neg   <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_AA_RED;
                    end
                end
                S_AA_RED: begin
                    if (r_h >= PI_Q30) begin
                        r_h   <= r_h - PI_Q30;
                        r_neg <= !r_neg;
                    end
                    if (r_idx == 4'd1) begin
                        r_state <= S_AA_FOLD;
                    end else begin
                        r_idx <= r_idx + 4'd1;
                    end
                end
                S_AA_FOLD: begin
                    if (r_h > HALF_PI_Q30) begin
                        r_x    <= 32'(PI_Q30 - r_h);
                        r_cneg <= 1'b1;
                    end else begin
                        r_x    <= r_h[31:0];
                        r_cneg <= 1'b0;
                    end
                    r_state <= S_AA_X2_MUL;
                end
                S_AA_X2_MUL: r_state <= S_AA_X2_ACC;
                S_AA_X2_ACC: begin
                    r_x2      <= r_prod[61:30];
                    r_t       <= Q30_ONE[30:0];
                    r_ser_sin <= 1'b0;
                    r_idx     <= {1'b0, COS_LAST};
                    r_state   <= S_SER_MUL;
                end
                S_SER_MUL: r_state <= S_SER_DIV_GO;
                S_SER_DIV_GO: r_state <= S_SER_DIV_WAIT;
                S_SER_DIV_WAIT: begin
                    if (div_done) begin
                        r_t <= ser_t;
                        if (r_idx == 4'd0) begin
                            if (!r_ser_sin) begin
                                r_c       <= ser_t;
                                r_t       <= Q30_ONE[30:0];
                                r_ser_sin <= 1'b1;
                                r_idx     <= {1'b0, SIN_LAST};
                                r_state   <= S_SER_MUL;
                            end else begin
                                r_state <= S_AA_S_MUL;
                            end
                        end else begin
                            r_idx   <= r_idx - 4'd1;
                            r_state <= S_SER_MUL;
                        end
                    end
                end
                S_AA_S_MUL: r_state <= S_AA_S_ACC;
                S_AA_S_ACC: begin
                    r_s     <= r_prod[60:30];
                    r_idx   <= '0;
                    r_state <= S_VEC_MUL;
                end
                S_VEC_MUL: r_state <= S_VEC_DIV_GO;
                S_VEC_DIV_GO: r_state <= S_VEC_DIV_WAIT;
                S_VEC_DIV_WAIT: begin
                    if (div_done) begin
                        r_v[r_idx[1:0] + 2'd1] <= (rot_a[r_idx[1:0]][31] ^ r_neg) ?
                                                  -$signed(div_quot) : $signed(div_quot);
                        if (r_idx == 4'd2) begin
                            r_state <= S_AA_RAW;
                        end else begin
                            r_idx   <= r_idx + 4'd1;
                            r_state <= S_VEC_MUL;
                        end
                    end
                end
                S_AA_RAW: begin
                    r_v[0]    <= (r_cneg ^ r_neg) ? -$signed({33'd0, r_c})
                                                  : $signed({33'd0, r_c});
                    r_use_ref <= 1'b0;
                    r_state   <= S_C_INIT;
                end
                S_C_INIT: begin
                    for (int i = 0; i < 4; i++) begin
                        r_u[i] <= mag64(r_v[i]);
                    end
                    r_state <= S_C_SHIFT;
                end
                S_C_SHIFT: begin
                    priority if (m == 64'd0) begin
                        r_o     <= '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
                        r_state <= S_RET;
                    end else if (m >= {32'd0, Q30_ONE}) begin
                        for (int i = 0; i < 4; i++) begin
                            r_u[i] <= r_u[i] >> 1;
                        end
                    end else if (m < {34'd0, NORM_LOW}) begin
                        for (int i = 0; i < 4; i++) begin
                            r_u[i] <= r_u[i] << 1;
                        end
                    end else begin
                        r_acc   <= '0;
                        r_idx   <= '0;
                        r_state <= S_C_SQ_MUL;
                    end
                end
                S_C_SQ_MUL: r_state <= S_C_SQ_ACC;
                S_C_SQ_ACC: begin
                    r_acc <= acc_sum;
                    if (r_idx == 4'd3) begin
                        r_state <= S_C_SQRT_GO;
                    end else begin
                        r_idx   <= r_idx + 4'd1;
                        r_state <= S_C_SQ_MUL;
                    end
                end
                S_C_SQRT_GO: r_state <= S_C_SQRT_WAIT;
                S_C_SQRT_WAIT: begin
                    if (sq_done) begin
                        r_n     <= sq_root;
                        r_idx   <= '0;
                        r_state <= S_C_DIV_GO;
                    end
                end
                S_C_DIV_GO: r_state <= S_C_DIV_WAIT;
                S_C_DIV_WAIT: begin
                    if (div_done) begin
                        r_o[r_idx[1:0]] <= r_v[r_idx[1:0]][63] ? -$signed(qlo) : $signed(qlo);
                        if (r_idx == 4'd3) begin
                            r_idx   <= '0;
                            r_acc   <= '0;
                            r_state <= r_use_ref ? S_C_DOT_MUL : S_C_FLIP;
                        end else begin
                            r_idx   <= r_idx + 4'd1;
                            r_state <= S_C_DIV_GO;
                        end
                    end
                end
                S_C_DOT_MUL: r_state <= S_C_DOT_ACC;
                S_C_DOT_ACC: begin
                    r_acc <= acc_sum;
                    if (r_idx == 4'd3) begin
                        r_state <= S_C_FLIP;
                    end else begin
                        r_idx   <= r_idx + 4'd1;
                        r_state <= S_C_DOT_MUL;
                    end
                end
                S_C_FLIP: begin
                    if (flip) begin
                        for (int i = 0; i < 4; i++) begin
                            r_o[i] <= -r_o[i];
                        end
                    end
                    r_state <= S_RET;
                end
                S_RET: begin
                    unique case (r_phase)
                        PH_AA: begin
                            r_dq <= r_o;
                            if (r_item.req_type == REQ_DELTA) begin
                                if (!r_has_ref) begin
                                    r_refpos  <= r_spos;
                                    r_v       <= '{sx64(r_sq[0]), sx64(r_sq[1]),
                                                   sx64(r_sq[2]), sx64(r_sq[3])};
                                    r_phase   <= PH_SEED;
                                    r_use_ref <= 1'b0;
                                    r_state   <= S_C_INIT;
                                end else begin
                                    r_state <= S_DELTA;
                                end
                            end else begin
                                r_v       <= '{sx64(r_o[0]), sx64(r_o[1]),
                                               sx64(r_o[2]), sx64(r_o[3])};
                                r_phase   <= PH_FINAL;
                                r_use_ref <= r_has_ref;
                                r_state   <= S_C_INIT;
                            end
                        end
                        PH_SEED: begin
                            r_refq    <= r_o;
                            r_has_ref <= 1'b1;
                            r_state   <= S_DELTA;
                        end
                        PH_Q1: begin
                            r_v       <= '{sx64(r_o[0]), sx64(r_o[1]),
                                           sx64(r_o[2]), sx64(r_o[3])};
                            r_phase   <= PH_FINAL;
                            r_use_ref <= r_has_ref;
                            r_state   <= S_C_INIT;
                        end
                        PH_FINAL: begin
                            r_refq <= r_o;
                            if (r_item.req_type != REQ_DELTA) begin
                                r_refpos  <= pos_a;
                                r_has_ref <= 1'b1;
                            end
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_DELTA: begin
                    for (int i = 0; i < 3; i++) begin
                        r_refpos[i] <= sat_add(r_refpos[i], pos_a[i]);
                    end
                    for (int i = 0; i < 4; i++) begin
                        r_v[i] <= '0;
                    end
                    r_idx   <= '0;
                    r_state <= S_HAM_MUL;
                end
                S_HAM_MUL: r_state <= S_HAM_ACC;
                S_HAM_ACC: begin
                    r_v[ham_k] <= ham_neg(ham_k, ham_j) ? (r_v[ham_k] - $signed(r_prod))
                                                        : (r_v[ham_k] + $signed(r_prod));
                    if (r_idx == 4'd15) begin
                        r_phase   <= PH_FINAL;
                        r_use_ref <= 1'b1;
                        r_state   <= S_C_INIT;
                    end else begin
                        r_idx   <= r_idx + 4'd1;
                        r_state <= S_HAM_MUL;
                    end
                end
                S_OUT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_OUT) && i_out_free;

    always_comb begin
        o_res.goal_kind = r_twist ? GOAL_TWIST : GOAL_POSE;
        o_res.lin_x     = r_twist ? r_item.pos_x : r_refpos[0];
        o_res.lin_y     = r_twist ? r_item.pos_y : r_refpos[1];
        o_res.lin_z     = r_twist ? r_item.pos_z : r_refpos[2];
        o_res.ang_x     = r_twist ? r_item.rot_ax : r_o[1];
        o_res.ang_y     = r_twist ? r_item.rot_ay : r_o[2];
        o_res.ang_z     = r_twist ? r_item.rot_az : r_o[3];
        o_res.ang_w     = r_twist ? 32'sd0 : r_o[0];
    end

`ifndef SYNTHESIS
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_out_free)
        else $error("result issued while the output register is full");
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_busy)
        else $error("core still busy after issuing a result");
    a_norm_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_C_DIV_GO) |-> (r_n >= {2'b00, NORM_LOW}))
        else $error("normalization root below range");
    a_ang_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VEC_DIV_GO) |-> (r_ang != 32'd0))
        else $error("axis divide by zero angle");
`endif
endmodule

// ----- src/pose_goal_accumulator.sv -----
`timescale 1ns / 1ps
// A pose sample is absorbed on acceptance; a twist-mode goal moves on to the output register
// once it is free, and the next request can be taken after the goal has been handed over.
// A pose goal runs a shared 33x33 multiplier, a radix-2 divider and a square root in turn;
// it is done soonest for an all-zero quaternion and takes longest for the first delta goal,
// mostly in divider time. One request is in work at a time.
// Synchronous active-low reset restores identity orientations, zero positions, no reference.

module pose_goal_accumulator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pga_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pga_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);
    import pga_pkg::*;

    logic r_mode;
    logic r_out_valid;
    t_out r_out;
    logic core_busy;
    logic core_res_valid;
    t_out core_res;
    logic in_acc;

    assign o_in_stall  = core_busy;
    assign in_acc      = i_in_valid && !core_busy;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    pga_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc),
        .i_item      (i_in_data),
        .i_mode      (r_mode),
        .i_out_free  (!r_out_valid),
        .o_busy      (core_busy),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (core_res_valid) begin
                r_out_valid <= 1'b1;
                r_out       <= core_res;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule
